### rtl/dlfp_pkg.sv
// Shared types and constants for the display link frame parser.
package dlfp_pkg;

  // Largest payload the frame store can hold.
  localparam int MAX_PAYLOAD = 60;
  localparam int STORE_AW    = $clog2(MAX_PAYLOAD);

  // Field widths.
  localparam int LEN_W  = 6;
  localparam int ADDR_W = 16;
  localparam int BYTE_W = 8;
  localparam int CFG_IW = 2;

  // Command bytes and the write-OK body.
  localparam logic [7:0] CMD_WRITE = 8'h82;
  localparam logic [7:0] CMD_READ  = 8'h83;
  localparam logic [7:0] OK_FIRST  = 8'h4F;
  localparam logic [7:0] OK_SECOND = 8'h4B;

  // Reset values of the configuration registers.
  localparam logic [7:0]       HEADER_FIRST_RST  = 8'h5A;
  localparam logic [7:0]       HEADER_SECOND_RST = 8'hA5;
  localparam logic [LEN_W-1:0] LENGTH_LIMIT_RST  = 6'd60;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_LENGTH_LIMIT  = 2'd2
  } cfg_index_t;

  // Input beat modes.
  typedef enum logic [1:0] {
    MODE_BYTE     = 2'd0,
    MODE_ARM_READ = 2'd1,
    MODE_ARM_ACK  = 2'd2,
    MODE_CANCEL   = 2'd3
  } mode_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_WRITE_ACK   = 3'd0,
    KIND_READ_DONE   = 3'd1,
    KIND_READ_EVENT  = 3'd2,
    KIND_WRITE_EVENT = 3'd3,
    KIND_DATA        = 3'd4
  } kind_t;

  // Receive parser phases.
  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_LENGTH      = 2'd2,
    PH_PAYLOAD     = 2'd3
  } phase_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_HEAD = 2'd1,
    ST_READ = 2'd2,
    ST_DATA = 2'd3
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ready;
    logic load_head;
    logic rd_issue;
    logic load_data;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic frame_done;
    logic head_emit;
    logic run_empty;
    logic run_last;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/dlfp_if.sv
// Handshake channels for input items and result beats.
interface dlfp_in_if;
  import dlfp_pkg::*;

  logic                valid;
  logic                ready;
  mode_t               mode;
  logic [BYTE_W-1:0]   rx_byte;
  logic [ADDR_W-1:0]   read_address;
  logic [7:0]          read_words;

  modport source (output valid, mode, rx_byte, read_address, read_words, input ready);
  modport sink   (input valid, mode, rx_byte, read_address, read_words, output ready);
endinterface

interface dlfp_out_if;
  import dlfp_pkg::*;

  logic               valid;
  logic               ready;
  kind_t              kind;
  logic [ADDR_W-1:0]  address;
  logic [7:0]         word_count;
  logic [LEN_W-1:0]   data_length;
  logic [BYTE_W-1:0]  data_byte;
  logic               last;

  modport source (output valid, kind, address, word_count, data_length, data_byte, last,
                  input ready);
  modport sink   (input valid, kind, address, word_count, data_length, data_byte, last,
                  output ready);
endinterface

### rtl/dlfp_ctrl.sv
// Controller that sequences frame reports: header beat, then data beats.
module dlfp_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  dlfp_pkg::dp_stat_t    stat,
  output dlfp_pkg::ctrl_cmd_t   cmd
);
  import dlfp_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && stat.frame_done) begin
          state_next = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (!stat.head_emit) begin
          state_next = ST_IDLE;
        end else if (stat.out_free) begin
          state_next = stat.run_empty ? ST_IDLE : ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_DATA;
      end
      ST_DATA: begin
        if (stat.out_free) begin
          state_next = stat.run_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Commands.
  always_comb begin
    cmd = '0;
    unique case (state)
      ST_IDLE: cmd.ready     = 1'b1;
      ST_HEAD: cmd.load_head = stat.head_emit && stat.out_free;
      ST_READ: cmd.rd_issue  = 1'b1;
      ST_DATA: cmd.load_data = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/dlfp_dp.sv
// Datapath: configuration, receive parser, frame store, waits and result register.
module dlfp_dp (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [dlfp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [dlfp_pkg::BYTE_W-1:0]  cfg_data,
  input  dlfp_pkg::ctrl_cmd_t          cmd,
  output dlfp_pkg::dp_stat_t           stat,
  dlfp_in_if.sink                      item_in,
  dlfp_out_if.source                   result_out
);
  import dlfp_pkg::*;

  // Configuration registers.
  logic [7:0]       header_first;
  logic [7:0]       header_second;
  logic [LEN_W-1:0] length_limit;

  // Parser state.
  phase_t           phase;
  phase_t           phase_next;
  logic [LEN_W-1:0] expected_length;
  logic [LEN_W-1:0] expected_length_next;
  logic [LEN_W-1:0] byte_index;
  logic [LEN_W-1:0] byte_index_next;
  logic [LEN_W-1:0] index_inc;
  logic             store_en;
  logic             take;
  logic             length_bad;
  logic [7:0]       rx;

  // Frame store and the first four payload bytes.
  logic [7:0]       frame_store [MAX_PAYLOAD];
  logic [7:0]       head_bytes [4];
  logic [7:0]       rd_data;

  // Waits.
  logic              ack_pending;
  logic              read_pending;
  logic [ADDR_W-1:0] pending_address;
  logic [8:0]        pending_bytes;

  // Classification of the finished frame.
  logic [ADDR_W-1:0] frame_addr;
  logic [LEN_W-1:0]  raw_len;
  logic [LEN_W-1:0]  write_len;
  logic              cls_emit;
  kind_t             cls_kind;
  logic [7:0]        cls_wc;
  logic [LEN_W-1:0]  cls_n;
  logic [LEN_W-1:0]  cls_start;
  logic              cls_clear_ack;
  logic              cls_clear_read;

  // Run counters.
  logic [LEN_W-1:0]  run_ptr;
  logic [LEN_W-1:0]  run_rem;

  assign take          = item_in.valid && item_in.ready;
  assign item_in.ready = cmd.ready && !rst;
  assign rx            = item_in.rx_byte;
  assign index_inc     = byte_index + LEN_W'(1);
  assign length_bad    = (rx == 8'd0) || (rx > {2'b00, length_limit}) ||
                         (rx > 8'(MAX_PAYLOAD));

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      header_first  <= HEADER_FIRST_RST;
      header_second <= HEADER_SECOND_RST;
      length_limit  <= LENGTH_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first  <= cfg_data;
        CFG_HEADER_SECOND: header_second <= cfg_data;
        CFG_LENGTH_LIMIT:  length_limit  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Parser next state for a received byte.
  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    byte_index_next      = byte_index;
    store_en             = 1'b0;
    if (take && item_in.mode == MODE_BYTE) begin
      unique case (phase)
        PH_HUNT_FIRST: begin
          if (rx == header_first) begin
            phase_next = PH_HUNT_SECOND;
          end
        end
        PH_HUNT_SECOND: begin
          if (rx == header_second) begin
            phase_next = PH_LENGTH;
          end else if (rx == header_first) begin
            phase_next = PH_HUNT_SECOND;
          end else begin
            phase_next = PH_HUNT_FIRST;
          end
        end
        PH_LENGTH: begin
          byte_index_next = '0;
          if (length_bad) begin
            expected_length_next = '0;
            phase_next           = PH_HUNT_FIRST;
          end else begin
            expected_length_next = rx[LEN_W-1:0];
            phase_next           = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          store_en        = byte_index < LEN_W'(MAX_PAYLOAD);
          byte_index_next = index_inc;
          if (index_inc >= expected_length) begin
            phase_next = PH_HUNT_FIRST;
          end
        end
        default: phase_next = PH_HUNT_FIRST;
      endcase
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT_FIRST;
      expected_length <= '0;
      byte_index      <= '0;
    end else begin
      phase           <= phase_next;
      expected_length <= expected_length_next;
      byte_index      <= byte_index_next;
    end
  end

  // Frame store: written by the parser, read one data byte at a time.
  always_ff @(posedge clk) begin
    if (store_en) begin
      frame_store[byte_index[STORE_AW-1:0]] <= rx;
    end
    if (cmd.rd_issue) begin
      rd_data <= frame_store[run_ptr[STORE_AW-1:0]];
    end
  end

  // The command, address and count bytes are kept in registers as well.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      if (store_en && byte_index == LEN_W'(k)) begin
        head_bytes[k] <= rx;
      end
    end
  end

  // Classify the finished frame from the held bytes and the waits.
  assign frame_addr = {head_bytes[1], head_bytes[2]};
  assign raw_len    = expected_length - LEN_W'(4);
  assign write_len  = expected_length - LEN_W'(3);

  always_comb begin
    cls_emit       = 1'b0;
    cls_kind       = KIND_WRITE_ACK;
    cls_wc         = '0;
    cls_n          = '0;
    cls_start      = '0;
    cls_clear_ack  = 1'b0;
    cls_clear_read = 1'b0;
    if (head_bytes[0] == CMD_WRITE && expected_length == LEN_W'(3) &&
        head_bytes[1] == OK_FIRST && head_bytes[2] == OK_SECOND) begin
      cls_emit      = ack_pending;
      cls_clear_ack = 1'b1;
    end else if (head_bytes[0] == CMD_READ) begin
      if (expected_length >= LEN_W'(4)) begin
        cls_emit  = 1'b1;
        cls_wc    = head_bytes[3];
        cls_start = LEN_W'(4);
        if (read_pending && pending_address == frame_addr) begin
          cls_kind       = KIND_READ_DONE;
          cls_clear_read = 1'b1;
          cls_n = ({3'b000, raw_len} < pending_bytes) ? raw_len : pending_bytes[LEN_W-1:0];
        end else begin
          cls_kind = KIND_READ_EVENT;
          cls_n    = raw_len;
        end
      end
    end else if (head_bytes[0] == CMD_WRITE) begin
      if (expected_length >= LEN_W'(3)) begin
        cls_emit  = 1'b1;
        cls_kind  = KIND_WRITE_EVENT;
        cls_wc    = {3'b000, write_len[LEN_W-1:1]};
        cls_start = LEN_W'(3);
        cls_n     = write_len;
      end
    end
  end

  // Waits: armed and cancelled by control beats, cleared by a report.
  always_ff @(posedge clk) begin
    if (rst) begin
      ack_pending     <= 1'b0;
      read_pending    <= 1'b0;
      pending_address <= '0;
      pending_bytes   <= '0;
    end else begin
      if (take) begin
        unique case (item_in.mode)
          MODE_ARM_READ: begin
            pending_address <= item_in.read_address;
            pending_bytes   <= {item_in.read_words, 1'b0};
            read_pending    <= 1'b1;
          end
          MODE_ARM_ACK: ack_pending <= 1'b1;
          MODE_CANCEL: begin
            ack_pending  <= 1'b0;
            read_pending <= 1'b0;
          end
          default: ;
        endcase
      end
      if (cmd.load_head) begin
        if (cls_clear_ack) begin
          ack_pending <= 1'b0;
        end
        if (cls_clear_read) begin
          read_pending <= 1'b0;
        end
      end
    end
  end

  // Run pointer and remaining count.
  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      run_ptr <= cls_start;
      run_rem <= cls_n;
    end else if (cmd.load_data) begin
      run_ptr <= run_ptr + LEN_W'(1);
      run_rem <= run_rem - LEN_W'(1);
    end
  end

  // Result register: valid is control, the payload needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (cmd.load_head || cmd.load_data) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_head) begin
      result_out.kind        <= cls_kind;
      result_out.address     <= (cls_kind == KIND_WRITE_ACK) ? '0 : frame_addr;
      result_out.word_count  <= cls_wc;
      result_out.data_length <= cls_n;
      result_out.data_byte   <= '0;
      result_out.last        <= (cls_n == '0);
    end else if (cmd.load_data) begin
      result_out.kind        <= KIND_DATA;
      result_out.address     <= '0;
      result_out.word_count  <= '0;
      result_out.data_length <= '0;
      result_out.data_byte   <= rd_data;
      result_out.last        <= (run_rem == LEN_W'(1));
    end
  end

  // Status to the controller.
  assign stat.frame_done = (item_in.mode == MODE_BYTE) && (phase == PH_PAYLOAD) &&
                           (index_inc >= expected_length);
  assign stat.head_emit  = cls_emit;
  assign stat.run_empty  = (cls_n == '0);
  assign stat.run_last   = (run_rem == LEN_W'(1));
  assign stat.out_free   = !result_out.valid || result_out.ready;

endmodule

### rtl/display_link_frame_parser.sv
// Top level of the display link frame parser.
//
//   channel     dir  handshake        payload
//   item_in     in   valid / ready    mode, rx_byte, read_address, read_words
//   result_out  out  valid / ready    kind, address, word_count, data_length,
//                                     data_byte, last
//   cfg         in   cfg_we           cfg_index, cfg_data
//
// A byte or control beat is taken while the controller is idle. A completed frame then
// goes through classification and the header beat, then each data byte is read through
// the registered read port of the frame store before its beat; up to 57 data bytes.
// Input is held off until the last beat of a report is in the result register.
// Stalls on result_out hold the controller; reset is synchronous and needs no sweep.
module display_link_frame_parser (
  input  logic                         clk,
  input  logic                         rst,
  dlfp_in_if.sink                      item_in,
  dlfp_out_if.source                   result_out,
  input  logic                         cfg_we,
  input  logic [dlfp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [dlfp_pkg::BYTE_W-1:0]  cfg_data
);
  import dlfp_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Report sequencer.
  dlfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item_in.valid),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Parser, frame store and result register.
  dlfp_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .stat       (stat),
    .item_in    (item_in),
    .result_out (result_out)
  );

endmodule

### sim/tb_display_link_frame_parser.sv
// Self-checking testbench for the display link frame parser.
module tb_display_link_frame_parser;
  import dlfp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE_TICKS = 150;
  localparam int MAX_SHOWN    = 10;

  // One input beat, with an optional hand-written header expectation.
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  rx;
    logic [15:0] addr;
    logic [7:0]  words;
    logic        typed;
    kind_t       kind;
    logic [15:0] exp_addr;
    logic [7:0]  exp_wc;
    logic [5:0]  exp_len;
  } stim_row_t;

  // One result beat as the block reports it.
  typedef struct packed {
    kind_t       kind;
    logic [15:0] address;
    logic [7:0]  word_count;
    logic [5:0]  data_length;
    logic [7:0]  data_byte;
    logic        last;
  } report_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_we;
  cfg_index_t              cfg_index;
  logic [BYTE_W-1:0]       cfg_data;

  dlfp_in_if  item_ch ();
  dlfp_out_if report_ch ();

  display_link_frame_parser i_dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_ch),
    .result_out (report_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Configuration as the parser should currently see it.
  logic [7:0]  hdr_first;
  logic [7:0]  hdr_second;
  logic [5:0]  len_limit;

  // Parser and wait state of the predictor.
  phase_t      rx_phase;
  logic [5:0]  want_len;
  logic [5:0]  fill_idx;
  logic [7:0]  payload_mem [MAX_PAYLOAD];
  logic        ack_wait;
  logic        read_wait;
  logic [15:0] wait_addr;
  logic [8:0]  wait_bytes;

  // Result beats still owed by the block, oldest first.
  report_t     report_q [$];

  stim_row_t   cur_row;
  logic        calm;
  logic        tally;
  logic [15:0] armed_addr;
  int          counted_items;
  int          beats_taken;
  int          results_seen;
  int          frames_seen;
  int          mismatches;
  int          cycle_count;
  int          settings_run;

  // Directed opening: default headers 5A A5, length limit 60.
  stim_row_t directed_tab [27] = '{
    '{MODE_ARM_READ, 8'h00, 16'hFFFF, 8'hFF, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_CANCEL,   8'hFF, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_ARM_ACK,  8'h00, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h5A, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h5A, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hA5, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h03, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h82, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h4F, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h4B, 16'h0000, 8'h00, 1'b1, KIND_WRITE_ACK,  16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h5A, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hA5, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h00, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h5A, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hA5, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hFF, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_ARM_READ, 8'h00, 16'h1234, 8'h01, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h5A, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hA5, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h07, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h83, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h12, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h34, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h01, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'h00, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hFF, 16'h0000, 8'h00, 1'b0, KIND_DATA,       16'h0000, 8'h00, 6'd0},
    '{MODE_BYTE,     8'hCC, 16'h0000, 8'h00, 1'b1, KIND_READ_DONE,  16'h1234, 8'h01, 6'd2}
  };

  // Queue one header beat and the data beats taken from the frame store.
  function automatic void queue_run(input kind_t k, input logic [15:0] addr,
                                    input logic [7:0] wc, input int unsigned start,
                                    input int unsigned n);
    report_t r;
    r.kind        = k;
    r.address     = addr;
    r.word_count  = wc;
    r.data_length = n[5:0];
    r.data_byte   = 8'h00;
    r.last        = (n == 0);
    report_q.push_back(r);
    for (int unsigned i = 0; i < n; i++) begin
      r.kind        = KIND_DATA;
      r.address     = 16'h0000;
      r.word_count  = 8'h00;
      r.data_length = 6'd0;
      r.data_byte   = payload_mem[start + i];
      r.last        = (i + 1 == n);
      report_q.push_back(r);
    end
  endfunction

  // Classify a completed frame and queue what it reports.
  function automatic void close_frame();
    int unsigned len;
    int unsigned raw;
    int unsigned n;
    logic [15:0] addr;
    len = want_len;
    if (payload_mem[0] == CMD_WRITE && len == 3 &&
        payload_mem[1] == OK_FIRST && payload_mem[2] == OK_SECOND) begin
      // The acknowledge only counts while a write is waiting for it.
      if (ack_wait) begin
        ack_wait = 1'b0;
        queue_run(KIND_WRITE_ACK, 16'h0000, 8'h00, 0, 0);
      end
    end else if (payload_mem[0] == CMD_READ) begin
      if (len >= 4) begin
        addr = {payload_mem[1], payload_mem[2]};
        raw  = len - 4;
        if (read_wait && wait_addr == addr) begin
          n         = (raw < wait_bytes) ? raw : wait_bytes;
          read_wait = 1'b0;
          queue_run(KIND_READ_DONE, addr, payload_mem[3], 4, n);
        end else begin
          queue_run(KIND_READ_EVENT, addr, payload_mem[3], 4, raw);
        end
      end
    end else if (payload_mem[0] == CMD_WRITE && len >= 3) begin
      addr = {payload_mem[1], payload_mem[2]};
      queue_run(KIND_WRITE_EVENT, addr, 8'((len - 3) / 2), 3, len - 3);
    end
  endfunction

  // Advance the predicted parser by one accepted input beat.
  function automatic void predict_item(input stim_row_t it);
    case (it.mode)
      MODE_ARM_READ: begin
        wait_addr  = it.addr;
        wait_bytes = {it.words, 1'b0};
        read_wait  = 1'b1;
      end
      MODE_ARM_ACK: ack_wait = 1'b1;
      MODE_CANCEL: begin
        ack_wait  = 1'b0;
        read_wait = 1'b0;
      end
      default: begin
        case (rx_phase)
          PH_HUNT_FIRST: begin
            if (it.rx == hdr_first) rx_phase = PH_HUNT_SECOND;
          end
          PH_HUNT_SECOND: begin
            if (it.rx == hdr_second) rx_phase = PH_LENGTH;
            else if (it.rx == hdr_first) rx_phase = PH_HUNT_SECOND;
            else rx_phase = PH_HUNT_FIRST;
          end
          PH_LENGTH: begin
            fill_idx = 6'd0;
            if (it.rx == 8'd0 || it.rx > len_limit || it.rx > MAX_PAYLOAD) begin
              want_len = 6'd0;
              rx_phase = PH_HUNT_FIRST;
            end else begin
              want_len = it.rx[5:0];
              rx_phase = PH_PAYLOAD;
            end
          end
          default: begin
            if (fill_idx < MAX_PAYLOAD) payload_mem[fill_idx] = it.rx;
            fill_idx = fill_idx + 6'd1;
            if (fill_idx >= want_len) begin
              rx_phase = PH_HUNT_FIRST;
              close_frame();
            end
          end
        endcase
      end
    endcase
  endfunction

  function automatic string fmt_report(input report_t r);
    return $sformatf("kind %0d addr %h wc %h len %0d byte %h last %b", r.kind, r.address,
                     r.word_count, r.data_length, r.data_byte, r.last);
  endfunction

  function automatic stim_row_t ctrl_row(input mode_t m, input logic [15:0] addr,
                                         input logic [7:0] words);
    stim_row_t row;
    row       = '0;
    row.mode  = m;
    row.rx    = 8'($urandom());
    row.addr  = addr;
    row.words = words;
    row.kind  = KIND_DATA;
    return row;
  endfunction

  // Pick a payload length of at least lo, mostly short, sometimes the limit.
  function automatic int unsigned pick_len(input int unsigned lo);
    int unsigned hi;
    if (len_limit < lo) return lo;
    if ($urandom_range(9) == 0) return len_limit;
    hi = (lo + 6 < len_limit) ? lo + 6 : len_limit;
    return $urandom_range(hi, lo);
  endfunction

  always #10 clk = ~clk;

  // Abort a run that stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d result beats outstanding",
               cycle_count, report_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Result side stalls about 15 percent of the time outside calm stretches.
  always @(negedge clk) begin
    report_ch.ready <= calm || ($urandom_range(99) >= 15);
  end

  // Predict on each accepted input beat, check each accepted result beat.
  always @(posedge clk) begin
    int      base;
    report_t got;
    report_t want;
    if (!rst) begin
      if (item_ch.valid && item_ch.ready) begin
        base = report_q.size();
        predict_item(cur_row);
        beats_taken++;
        if (cur_row.typed) begin
          want.kind        = cur_row.kind;
          want.address     = cur_row.exp_addr;
          want.word_count  = cur_row.exp_wc;
          want.data_length = cur_row.exp_len;
          want.data_byte   = 8'h00;
          want.last        = (cur_row.exp_len == 6'd0);
          if (report_q.size() > base) report_q[base] = want;
          else report_q.push_back(want);
        end
      end
      if (report_ch.valid && report_ch.ready) begin
        got = {report_ch.kind, report_ch.address, report_ch.word_count,
               report_ch.data_length, report_ch.data_byte, report_ch.last};
        results_seen++;
        if (got.kind != KIND_DATA) frames_seen++;
        if (report_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display("Unexpected result beat: %s", fmt_report(got));
        end else begin
          want = report_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
              $display("Result beat %0d differs: expected %s, got %s", results_seen,
                       fmt_report(want), fmt_report(got));
          end
        end
      end
    end
  end

  // Offer one input beat and hold it until the parser takes it.
  task automatic send_row(input stim_row_t row);
    while (!calm && $urandom_range(99) < 15) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cur_row = row;
    item_ch.valid        <= 1'b1;
    item_ch.mode         <= row.mode;
    item_ch.rx_byte      <= row.rx;
    item_ch.read_address <= row.addr;
    item_ch.read_words   <= row.words;
    if (tally) counted_items++;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_byte(input logic [7:0] b);
    stim_row_t row;
    row      = ctrl_row(MODE_BYTE, 16'($urandom()), 8'($urandom()));
    row.rx   = b;
    send_row(row);
  endtask

  task automatic send_header(input logic [7:0] len);
    send_byte(hdr_first);
    send_byte(hdr_second);
    send_byte(len);
  endtask

  // Well-formed frame with random content, sometimes preceded by an armed wait.
  task automatic send_frame();
    logic [7:0]  body [$];
    logic [7:0]  cmd;
    logic [15:0] addr;
    int unsigned pick;
    int unsigned len;
    pick = $urandom_range(99);
    addr = 16'($urandom());
    if (pick < 15) begin
      if ($urandom_range(1)) send_row(ctrl_row(MODE_ARM_ACK, 16'($urandom()), 8'($urandom())));
      body = '{CMD_WRITE, OK_FIRST, OK_SECOND};
    end else if (pick < 45) begin
      if ($urandom_range(9) < 6) begin
        armed_addr = 16'($urandom());
        send_row(ctrl_row(MODE_ARM_READ, armed_addr,
                          ($urandom_range(9) == 0) ? 8'hFF : 8'($urandom_range(12))));
      end
      if ($urandom_range(3) != 0) addr = armed_addr;
      len  = pick_len(4);
      body = '{CMD_READ, addr[15:8], addr[7:0]};
    end else if (pick < 70) begin
      len  = pick_len(3);
      body = '{CMD_WRITE, addr[15:8], addr[7:0]};
    end else if (pick < 80) begin
      // Read or write frames too short to carry their full header.
      if ($urandom_range(1)) begin
        len  = $urandom_range(3, 1);
        body = '{CMD_READ};
      end else begin
        len  = $urandom_range(2, 1);
        body = '{CMD_WRITE};
      end
    end else begin
      do cmd = 8'($urandom()); while (cmd == CMD_WRITE || cmd == CMD_READ);
      len  = pick_len(1);
      body = '{cmd};
    end
    while (body.size() < len) body.push_back(8'($urandom()));
    send_header(8'(body.size()));
    foreach (body[i]) send_byte(body[i]);
  endtask

  // Noise and broken frames.
  task automatic send_broken();
    logic [7:0]  b;
    int unsigned len;
    case ($urandom_range(4))
      0: begin
        tally = 1'b0;
        repeat ($urandom_range(4, 1)) send_byte(8'($urandom()));
        tally = 1'b1;
      end
      1: begin
        do b = 8'($urandom()); while (b == hdr_second);
        send_byte(hdr_first);
        send_byte(b);
      end
      2: send_header(8'h00);
      3: send_header(8'($urandom_range(255, len_limit + 1)));
      default: begin
        // Cut short: whatever follows fills the rest of the payload.
        len = pick_len(1);
        send_header(8'(len));
        repeat ($urandom_range(len - 1, 0)) send_byte(8'($urandom()));
      end
    endcase
  endtask

  // Drain all owed results, then leave room for any work still under way.
  task automatic settle();
    item_ch.valid <= 1'b0;
    while (report_q.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [7:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      CFG_HEADER_FIRST:  hdr_first = val;
      CFG_HEADER_SECOND: hdr_second = val;
      default:           len_limit = val[5:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int          quota [4];
    int          target;
    logic [7:0]  same;
    int unsigned roll;
    quota = '{20, 45, 40, 60};

    // Everything known from time zero; predictor starts from reset values.
    clk                  = 1'b0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = CFG_HEADER_FIRST;
    cfg_data             = '0;
    item_ch.valid        = 1'b0;
    item_ch.mode         = MODE_BYTE;
    item_ch.rx_byte      = '0;
    item_ch.read_address = '0;
    item_ch.read_words   = '0;
    report_ch.ready      = 1'b0;
    hdr_first            = HEADER_FIRST_RST;
    hdr_second           = HEADER_SECOND_RST;
    len_limit            = LENGTH_LIMIT_RST;
    rx_phase             = PH_HUNT_FIRST;
    want_len             = 6'd0;
    fill_idx             = 6'd0;
    ack_wait             = 1'b0;
    read_wait            = 1'b0;
    wait_addr            = 16'h0000;
    wait_bytes           = 9'd0;
    armed_addr           = 16'h0000;
    calm                 = 1'b0;
    tally                = 1'b1;
    cur_row              = '0;
    counted_items        = 0;
    beats_taken          = 0;
    results_seen         = 0;
    frames_seen          = 0;
    mismatches           = 0;
    cycle_count          = 0;
    settings_run         = 1;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed opening at the reset configuration.
    foreach (directed_tab[i]) send_row(directed_tab[i]);

    // Random phases, each under its own register setting.
    for (int p = 0; p < 4; p++) begin
      settle();
      case (p)
        0: begin
          write_reg(CFG_HEADER_FIRST, 8'h00);
          write_reg(CFG_HEADER_SECOND, 8'hFF);
          write_reg(CFG_LENGTH_LIMIT, 8'd1);
        end
        1: begin
          write_reg(CFG_HEADER_FIRST, 8'hFF);
          write_reg(CFG_HEADER_SECOND, 8'h00);
          write_reg(CFG_LENGTH_LIMIT, 8'(MAX_PAYLOAD));
        end
        2: begin
          // Identical header bytes check that the second-byte match wins over the retry.
          same = 8'($urandom());
          write_reg(CFG_HEADER_FIRST, same);
          write_reg(CFG_HEADER_SECOND, same);
          write_reg(CFG_LENGTH_LIMIT, 8'($urandom_range(MAX_PAYLOAD, 4)));
        end
        default: begin
          write_reg(CFG_HEADER_FIRST, 8'($urandom()));
          write_reg(CFG_HEADER_SECOND, 8'($urandom()));
          write_reg(CFG_LENGTH_LIMIT, 8'($urandom_range(MAX_PAYLOAD, 1)));
        end
      endcase
      settings_run++;
      calm   = (p == 1);
      target = counted_items + quota[p];
      while (counted_items < target) begin
        roll = $urandom_range(99);
        if (roll < 65) send_frame();
        else if (roll < 80) send_row(ctrl_row(mode_t'($urandom_range(3, 1)),
                                              16'($urandom()), 8'($urandom())));
        else send_broken();
      end
      calm = 1'b0;
    end
    settle();

    $display("Ran %0d input beats under %0d register settings.", beats_taken, settings_run);
    $display("Checked %0d result beats in %0d reports, %0d mismatches.", results_seen,
             frames_seen, mismatches);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
